// ===== rtl/mcws_pkg.sv =====
// shared types and constants of the markov chain walk sampler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mcws_pkg;

  // index field width inside the command queue, enough for 256 states
  localparam int IDX_W = 8;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // reset values of the configuration registers
  localparam logic [6:0]  NUM_STATES_RST = 7'd64;
  localparam logic [15:0] WALK_LEN_RST   = 16'd16;

  // configuration register indexes
  localparam logic CFG_NUM_STATES = 1'b0;
  localparam logic CFG_WALK_LEN   = 1'b1;

  // action codes of an input word
  localparam logic [1:0] ACT_WR_PROB  = 2'd0;
  localparam logic [1:0] ACT_WR_VALUE = 2'd1;
  localparam logic [1:0] ACT_START    = 2'd2;
  localparam logic [1:0] ACT_STEP     = 2'd3;

  typedef enum logic [1:0] {
    CMD_WR_PROB,
    CMD_WR_VALUE,
    CMD_START,
    CMD_STEP
  } cmd_op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_VALUE,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         from_state;
    logic [5:0]         to_state;
    logic [16:0]        probability;
    logic [5:0]         value_slot;
    logic signed [31:0] state_value;
    logic [5:0]         start_state;
    logic [15:0]        draw;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         state_index;
    logic signed [31:0] value_out;
    logic               no_transition;
    logic               end_of_walk;
  } out_word_t;

  // decoded command; row holds the row, the value slot or the start state
  typedef struct packed {
    cmd_op_e            op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [16:0]        prob;
    logic signed [31:0] value;
    logic [15:0]        draw;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/markov_chain_walk_sampler.sv =====
// markov chain walk sampler, top level: front decoder, command queue, back end
// depends on mcws_pkg, mcws_front, mcws_queue and mcws_back
`timescale 1ns / 1ps
`default_nettype none

// Walks a discrete-time Markov chain by inverse-CDF sampling. Words on the
// input channel either load the transition table (unsigned Q1.16 per entry,
// MAX_STATES x MAX_STATES), load a state's signed Q16.16 value, start a walk
// at a given state, or take one step with a uniform Q0.16 draw. A step scans
// the current row from column 0, summing probabilities mod 2^16, and moves to
// the first column whose running sum is greater than the draw; if none
// qualifies the state stays and no_transition is set. A start and every step
// inside a walk give one result word; the last state of a walk of walk_length
// states is flagged with end_of_walk, and steps outside a walk give nothing.
// Indices are taken modulo MAX_STATES, the scan caps the state count at
// MAX_STATES. Tables come up undefined: read only entries that were written.
// Timing: input words land in a two-entry queue, so the input side keeps
// moving while the back end works or the result waits, until it is full.
// The back end handles a table write in its idle state, a start in its
// value-read and emit states, and a step in a row scan followed by those
// states; a start or a step also waits while the result register still
// holds a word that has not been taken. The scan is bound by one read per
// cycle of the probability table. Configuration writes take effect on the
// next cycle and are meant to be made while no word is in flight.

module markov_chain_walk_sampler import mcws_pkg::*; #(
  parameter int MAX_STATES = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_word_t    in_word_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_word_t        out_word_o,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic push, full, pop, q_valid;
  cmd_t push_cmd, q_head;

  // decode and index wrap
  mcws_front #(
    .MAX_STATES (MAX_STATES)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  // decouples input acceptance from the scan
  mcws_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // tables, walk state, scan and result register
  mcws_back #(
    .MAX_STATES (MAX_STATES),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mcws_front.sv =====
// front end: decodes input words into commands and wraps indices
// depends on mcws_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcws_front import mcws_pkg::*; #(
  parameter int MAX_STATES = 64
) (
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  output logic          push_o,
  output cmd_t          push_cmd_o,
  input  wire logic     full_i
);

  // index modulo MAX_STATES, one conditional subtract per bit
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [5:0] v);
    logic [14:0] r;
    r = 15'(v);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (15'(MAX_STATES) << k)) begin
        r = r - (15'(MAX_STATES) << k);
      end
    end
    return IDX_W'(r);
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    push_cmd_o       = '0;
    push_cmd_o.prob  = in_word_i.probability;
    push_cmd_o.value = in_word_i.state_value;
    push_cmd_o.draw  = in_word_i.draw;
    push_cmd_o.col   = wrap_idx(in_word_i.to_state);
    case (in_word_i.action)
      ACT_WR_PROB: begin
        push_cmd_o.op  = CMD_WR_PROB;
        push_cmd_o.row = wrap_idx(in_word_i.from_state);
      end
      ACT_WR_VALUE: begin
        push_cmd_o.op  = CMD_WR_VALUE;
        push_cmd_o.row = wrap_idx(in_word_i.value_slot);
      end
      ACT_START: begin
        push_cmd_o.op  = CMD_START;
        push_cmd_o.row = wrap_idx(in_word_i.start_state);
      end
      default: begin
        push_cmd_o.op  = CMD_STEP;
        push_cmd_o.row = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mcws_queue.sv =====
// short command queue between front and back
// depends on mcws_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcws_queue import mcws_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      head_o
);

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slots_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcws_back.sv =====
// back end: tables, walk state, row scan and result register
// depends on mcws_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcws_back import mcws_pkg::*; #(
  parameter int MAX_STATES = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire cmd_t        q_head_i,
  output logic             q_pop_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_word_t        out_word_o
);

  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CW = $clog2(MAX_STATES + 1);
  localparam int AW = $clog2(MAX_STATES * MAX_STATES);

  back_state_e state_q, state_d;

  // memories
  logic [16:0]                  pmem [MAX_STATES * MAX_STATES];
  logic signed [VALUE_BITS-1:0] vmem [MAX_STATES];
  logic [16:0]                  pdata_q;
  logic signed [VALUE_BITS-1:0] vdata_q;
  logic                         pm_we, pm_re, vm_we, vm_re;
  logic [AW-1:0]                pm_waddr, pm_raddr;

  // configuration
  logic [6:0]  nos_q;
  logic [15:0] wlen_q;

  // walk state
  logic [SW-1:0] cur_q, cur_d;
  logic [15:0]   steps_q, steps_d;
  logic          active_q, active_d;

  // scan
  logic [CW-1:0] issue_q, issue_d;
  logic [CW-1:0] n_eff;
  logic [SW-1:0] chk_q, chk_d;
  logic          pend_q, pend_d;
  logic [15:0]   sum_q, sum_d;
  logic [17:0]   sum_nx;
  logic [15:0]   draw_q, draw_d;
  logic          hit, scan_done;
  logic          nt_q, nt_d;

  // result register
  out_word_t out_q;
  logic      out_valid_q, out_valid_d, out_load;
  logic      out_free;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    if (32'(nos_q) > 32'(MAX_STATES)) begin
      n_eff = CW'(MAX_STATES);
    end else begin
      n_eff = CW'(nos_q);
    end
  end

  assign sum_nx    = 18'(sum_q) + 18'(pdata_q);
  assign hit       = pend_q && (sum_nx > 18'(draw_q));
  assign scan_done = hit || (issue_q >= n_eff);

  assign pm_waddr = AW'(q_head_i.row[SW-1:0]) * AW'(MAX_STATES) + AW'(q_head_i.col[SW-1:0]);
  assign pm_raddr = AW'(cur_q) * AW'(MAX_STATES) + AW'(SW'(issue_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.op == CMD_START) begin
            state_d = BK_VALUE;
          end else if (q_head_i.op == CMD_STEP && active_q && steps_q < wlen_q) begin
            state_d = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_d = BK_VALUE;
        end
      end
      BK_VALUE: begin
        if (out_free) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop_o  = 1'b0;
    pm_we    = 1'b0;
    pm_re    = 1'b0;
    vm_we    = 1'b0;
    vm_re    = 1'b0;
    out_load = 1'b0;
    cur_d    = cur_q;
    steps_d  = steps_q;
    active_d = active_q;
    issue_d  = issue_q;
    chk_d    = chk_q;
    pend_d   = pend_q;
    sum_d    = sum_q;
    draw_d   = draw_q;
    nt_d     = nt_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_head_i.op)
            CMD_WR_PROB:  pm_we = 1'b1;
            CMD_WR_VALUE: vm_we = 1'b1;
            CMD_START: begin
              cur_d    = q_head_i.row[SW-1:0];
              steps_d  = 16'd1;
              active_d = (16'd1 < wlen_q);
              nt_d     = 1'b0;
            end
            CMD_STEP: begin
              if (active_q) begin
                if (steps_q >= wlen_q) begin
                  // walk length lowered under the count: walk ends silently
                  active_d = 1'b0;
                end else begin
                  draw_d  = q_head_i.draw;
                  issue_d = '0;
                  pend_d  = 1'b0;
                  sum_d   = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_SCAN: begin
        // one entry read per cycle, checked the cycle after
        if (issue_q < n_eff) begin
          pm_re   = 1'b1;
          issue_d = issue_q + 1'b1;
          chk_d   = SW'(issue_q);
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          sum_d = sum_nx[15:0];
        end
        if (scan_done) begin
          if (hit) begin
            cur_d = chk_q;
          end
          nt_d     = !hit;
          steps_d  = steps_q + 16'd1;
          active_d = ((steps_q + 16'd1) < wlen_q);
          pend_d   = 1'b0;
        end
      end
      BK_VALUE: begin
        if (out_free) begin
          vm_re = 1'b1;
        end
      end
      BK_EMIT: out_load = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      nos_q       <= NUM_STATES_RST;
      wlen_q      <= WALK_LEN_RST;
      cur_q       <= '0;
      steps_q     <= WALK_LEN_RST;
      active_q    <= 1'b0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      steps_q     <= steps_d;
      active_q    <= active_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_STATES) begin
          nos_q <= cfg_wdata_i[6:0];
        end else begin
          wlen_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q  <= chk_d;
    sum_q  <= sum_d;
    draw_q <= draw_d;
    nt_q   <= nt_d;
    if (out_load) begin
      out_q.state_index   <= 6'(cur_q);
      out_q.value_out     <= 32'(vdata_q);
      out_q.no_transition <= nt_q;
      out_q.end_of_walk   <= !active_q;
    end
  end

  // transition probability table
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pmem[pm_waddr] <= q_head_i.prob;
    end
    if (pm_re) begin
      pdata_q <= pmem[pm_raddr];
    end
  end

  // state value table
  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vmem[q_head_i.row[SW-1:0]] <= VALUE_BITS'(q_head_i.value);
    end
    if (vm_re) begin
      vdata_q <= vmem[cur_q];
    end
  end

endmodule

`default_nettype wire
